>>> design/bn3_pkg.sv
// bn3_pkg: shared types and constants of the normalized 3x3 blur.
// No dependencies.
`timescale 1ns / 1ps
package bn3_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 48;
  localparam int unsigned LL_BITS = 11;
  localparam int unsigned FL_BITS = 16;
  localparam int unsigned PIX_BITS = 24;
  localparam int unsigned QBIT_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LINES    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHTS_BEFORE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHTS_CENTER = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHTS_AFTER  = 3'd4;

  localparam logic [LL_BITS-1:0]       RST_LINE_LENGTH = 11'd1;
  localparam logic [FL_BITS-1:0]       RST_FRAME_LINES = 16'd1;
  localparam logic [CFG_DATA_BITS-1:0] RST_WEIGHTS_SIDE = 48'd17592722919424;
  localparam logic [CFG_DATA_BITS-1:0] RST_WEIGHTS_CENTER = 48'd35185445838848;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } bn3_state_t;

  typedef struct packed {
    logic                     clr;
    logic                     acc;
    logic                     div_init;
    logic                     div_step;
    logic [QBIT_IDX_BITS-1:0] bit_idx;
  } bn3_ctl_t;

endpackage

>>> design/bn3_ram.sv
// bn3_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bn3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/bn3_chan.sv
// bn3_chan: one color channel; serial multiply-accumulate over the taps,
// then bit-serial restoring divide with saturation. Uses bn3_pkg.
`timescale 1ns / 1ps
module bn3_chan #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  bn3_pkg::bn3_ctl_t             ctl,
  input  logic [7:0]                    sample,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  output logic [7:0]                    quot
);

  localparam int SW = WEIGHT_BITS + 13;
  localparam int WA = WEIGHT_BITS + 4;

  logic signed [SW-1:0]          s_acc_r, s_acc_nxt;
  logic signed [WA-1:0]          w_acc_r, w_acc_nxt;
  logic [SW-1:0]                 rem_r, rem_nxt;
  logic [WA-1:0]                 den_r, den_nxt;
  logic [7:0]                    q_r, q_nxt;
  logic                          zero_r, zero_nxt;
  logic                          sat_r, sat_nxt;
  logic signed [WEIGHT_BITS+8:0] prod;
  logic [SW-1:0]                 s_abs;
  logic [WA-1:0]                 w_abs;
  logic [SW-1:0]                 den_sh;

  assign prod = $signed({1'b0, sample}) * weight;
  assign s_abs = s_acc_r[SW-1] ? SW'(-s_acc_r) : SW'(s_acc_r);
  assign w_abs = w_acc_r[WA-1] ? WA'(-w_acc_r) : WA'(w_acc_r);
  assign den_sh = SW'(den_r) << ctl.bit_idx;

  always_comb begin
    s_acc_nxt = s_acc_r;
    w_acc_nxt = w_acc_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    zero_nxt = zero_r;
    sat_nxt = sat_r;
    if (ctl.clr) begin
      s_acc_nxt = '0;
      w_acc_nxt = '0;
    end else if (ctl.acc) begin
      s_acc_nxt = s_acc_r + SW'(prod);
      w_acc_nxt = w_acc_r + WA'(weight);
    end
    if (ctl.div_init) begin
      rem_nxt = s_abs;
      den_nxt = w_abs;
      q_nxt = '0;
      zero_nxt = (s_acc_r == '0) || (w_acc_r == '0) || (s_acc_r[SW-1] != w_acc_r[WA-1]);
      sat_nxt = s_abs >= (SW'(w_abs) << 8);
    end else if (ctl.div_step) begin
      if (rem_r >= den_sh) begin
        rem_nxt = rem_r - den_sh;
        q_nxt[ctl.bit_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_acc_r <= s_acc_nxt;
    w_acc_r <= w_acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r <= q_nxt;
    zero_r <= zero_nxt;
    sat_r <= sat_nxt;
  end

  assign quot = zero_r ? 8'd0 : (sat_r ? 8'd255 : q_r);

endmodule

>>> design/blur_3x3_normalized_border.sv
// blur_3x3_normalized_border: streaming normalized 3x3 RGB convolution.
// Flow: an accepted word updates the line stores; a word that completes a result then runs the serial
// tap accumulate and the serial divide. in_stall holds off the next word until the result is loaded
// into the output register, which waits for out_stall to release; a dropped drain word is not held.
// Reset: synchronous active-low; counters, control and config go to defaults.
// Line stores are not cleared. Uses bn3_pkg, bn3_ram, bn3_chan.
`timescale 1ns / 1ps
module blur_3x3_normalized_border #(
  parameter int MAX_LINE_LEN = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_red,
  input  logic [7:0]                          in_green,
  input  logic [7:0]                          in_blue,
  input  logic                                in_drain,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic                                out_last_of_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bn3_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [bn3_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int PW = $clog2(MAX_LINE_LEN);
  localparam int LW = $clog2(MAX_LINE_LEN + 1);
  localparam int FW = bn3_pkg::FL_BITS;
  localparam int EW = (3 * WEIGHT_BITS > 48) ? 3 * WEIGHT_BITS : 48;

  logic [bn3_pkg::LL_BITS-1:0]       line_length_r;
  logic [FW-1:0]                     frame_lines_r;
  logic [bn3_pkg::CFG_DATA_BITS-1:0] w_before_r, w_center_r, w_after_r;

  bn3_pkg::bn3_state_t state_r, state_nxt;
  logic [PW-1:0]       in_pos_r, out_pos_r, p_r;
  logic [FW:0]         in_line_r;
  logic [FW-1:0]       out_line_r;
  logic [23:0]         pixel_r;
  logic [23:0]         win_r [3][3];
  logic [1:0]          col_r, row_r;
  logic [2:0]          bit_r;
  logic                out_valid_r;
  logic [7:0]          out_red_r, out_green_r, out_blue_r;
  logic                out_last_r;

  logic [LW-1:0]       len;
  logic [FW-1:0]       lines;
  logic [PW-1:0]       p;
  logic                accept, flushing, ignore, emit, tap_last, out_free, last;
  logic                tap_used;
  logic [23:0]         older_rd, newer_rd, tap_pix;
  logic [EW-1:0]       wext;
  logic signed [WEIGHT_BITS-1:0] weight;
  bn3_pkg::bn3_ctl_t   ctl;
  logic [7:0]          q_red, q_green, q_blue;
  logic [PW:0]         in_pos_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r <= bn3_pkg::RST_LINE_LENGTH;
      frame_lines_r <= bn3_pkg::RST_FRAME_LINES;
      w_before_r <= bn3_pkg::RST_WEIGHTS_SIDE;
      w_center_r <= bn3_pkg::RST_WEIGHTS_CENTER;
      w_after_r <= bn3_pkg::RST_WEIGHTS_SIDE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bn3_pkg::REG_LINE_LENGTH:    line_length_r <= cfg_data[bn3_pkg::LL_BITS-1:0];
        bn3_pkg::REG_FRAME_LINES:    frame_lines_r <= cfg_data[FW-1:0];
        bn3_pkg::REG_WEIGHTS_BEFORE: w_before_r <= cfg_data;
        bn3_pkg::REG_WEIGHTS_CENTER: w_center_r <= cfg_data;
        bn3_pkg::REG_WEIGHTS_AFTER:  w_after_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_length_r == '0) begin
      len = LW'(1);
    end else if (int'(line_length_r) > MAX_LINE_LEN) begin
      len = LW'(MAX_LINE_LEN);
    end else begin
      len = LW'(line_length_r);
    end
  end
  assign lines = (frame_lines_r == '0) ? FW'(1) : frame_lines_r;
  assign p = ({1'b0, in_pos_r} >= len) ? PW'(len - LW'(1)) : in_pos_r;

  assign in_stall = (state_r != bn3_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign flushing = in_line_r >= {1'b0, lines};
  assign ignore = in_drain && !flushing;
  assign emit = (in_line_r >= (FW+1)'(2)) || ((in_line_r == (FW+1)'(1)) && (p_r != '0));
  assign tap_last = (col_r == 2'd2) && (row_r == 2'd2);
  assign out_free = !out_valid_r || !out_stall;
  assign last = ({1'b0, out_line_r} + (FW+1)'(1) >= {1'b0, lines})
             && ({1'b0, out_pos_r} + (PW+1)'(1) >= (PW+1)'(len));
  assign in_pos_inc = {1'b0, p_r} + (PW+1)'(1);

  bn3_ram #(.WIDTH(bn3_pkg::PIX_BITS), .DEPTH(MAX_LINE_LEN)) u_older (
    .clk(clk), .we(state_r == bn3_pkg::ST_READ), .waddr(p_r), .wdata(newer_rd),
    .re(accept), .raddr(p), .rdata(older_rd)
  );

  bn3_ram #(.WIDTH(bn3_pkg::PIX_BITS), .DEPTH(MAX_LINE_LEN)) u_newer (
    .clk(clk), .we(state_r == bn3_pkg::ST_READ), .waddr(p_r), .wdata(pixel_r),
    .re(accept), .raddr(p), .rdata(newer_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bn3_pkg::ST_IDLE:  if (accept && !ignore) state_nxt = bn3_pkg::ST_READ;
      bn3_pkg::ST_READ:  state_nxt = emit ? bn3_pkg::ST_MAC : bn3_pkg::ST_IDLE;
      bn3_pkg::ST_MAC:   if (tap_last) state_nxt = bn3_pkg::ST_DINIT;
      bn3_pkg::ST_DINIT: state_nxt = bn3_pkg::ST_DIV;
      bn3_pkg::ST_DIV:   if (bit_r == 3'd0) state_nxt = bn3_pkg::ST_DONE;
      bn3_pkg::ST_DONE:  if (out_free) state_nxt = bn3_pkg::ST_IDLE;
      default:           state_nxt = bn3_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    tap_used = !((col_r == 2'd0) && (out_pos_r == '0))
            && !((col_r == 2'd2) && ({1'b0, out_pos_r} + (PW+1)'(1) >= (PW+1)'(len)))
            && !((row_r == 2'd0) && (out_line_r == '0))
            && !((row_r == 2'd2) && ({1'b0, out_line_r} + (FW+1)'(1) >= {1'b0, lines}));
    ctl.clr = (state_r == bn3_pkg::ST_READ);
    ctl.acc = (state_r == bn3_pkg::ST_MAC) && tap_used;
    ctl.div_init = (state_r == bn3_pkg::ST_DINIT);
    ctl.div_step = (state_r == bn3_pkg::ST_DIV);
    ctl.bit_idx = bit_r;
  end

  always_comb begin
    unique case (col_r)
      2'd0:    wext = EW'(w_before_r);
      2'd1:    wext = EW'(w_center_r);
      default: wext = EW'(w_after_r);
    endcase
  end
  assign weight = $signed(wext[row_r*WEIGHT_BITS +: WEIGHT_BITS]);
  assign tap_pix = win_r[col_r][row_r];

  bn3_chan #(.WEIGHT_BITS(WEIGHT_BITS)) u_red (
    .clk(clk), .ctl(ctl), .sample(tap_pix[7:0]), .weight(weight), .quot(q_red)
  );
  bn3_chan #(.WEIGHT_BITS(WEIGHT_BITS)) u_green (
    .clk(clk), .ctl(ctl), .sample(tap_pix[15:8]), .weight(weight), .quot(q_green)
  );
  bn3_chan #(.WEIGHT_BITS(WEIGHT_BITS)) u_blue (
    .clk(clk), .ctl(ctl), .sample(tap_pix[23:16]), .weight(weight), .quot(q_blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bn3_pkg::ST_IDLE;
      in_pos_r <= '0;
      in_line_r <= '0;
      out_pos_r <= '0;
      out_line_r <= '0;
      out_valid_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
      bit_r <= '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[c][r] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if ((state_r == bn3_pkg::ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        bn3_pkg::ST_IDLE: begin
          if (accept && !ignore) begin
            p_r <= p;
            pixel_r <= flushing ? 24'd0 : {in_blue, in_green, in_red};
          end
        end
        bn3_pkg::ST_READ: begin
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2][0] <= older_rd;
          win_r[2][1] <= newer_rd;
          win_r[2][2] <= pixel_r;
          if (in_pos_inc >= (PW+1)'(len)) begin
            in_pos_r <= '0;
            in_line_r <= in_line_r + (FW+1)'(1);
          end else begin
            in_pos_r <= in_pos_inc[PW-1:0];
          end
          col_r <= '0;
          row_r <= '0;
        end
        bn3_pkg::ST_MAC: begin
          if (row_r == 2'd2) begin
            row_r <= '0;
            col_r <= col_r + 2'd1;
          end else begin
            row_r <= row_r + 2'd1;
          end
          bit_r <= 3'd7;
        end
        bn3_pkg::ST_DIV: begin
          bit_r <= bit_r - 3'd1;
        end
        bn3_pkg::ST_DONE: begin
          if (out_free) begin
            out_red_r <= q_red;
            out_green_r <= q_green;
            out_blue_r <= q_blue;
            out_last_r <= last;
            if (last) begin
              in_pos_r <= '0;
              in_line_r <= '0;
              out_pos_r <= '0;
              out_line_r <= '0;
            end else if ({1'b0, out_pos_r} + (PW+1)'(1) >= (PW+1)'(len)) begin
              out_pos_r <= '0;
              out_line_r <= out_line_r + FW'(1);
            end else begin
              out_pos_r <= out_pos_r + PW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_red = out_red_r;
  assign out_green = out_green_r;
  assign out_blue = out_blue_r;
  assign out_last_of_frame = out_last_r;

endmodule

>>> design/bn3_checker.sv
// bn3_checker: port-level assertions for blur_3x3_normalized_border.
// Bound to the top level; uses no package.
`timescale 1ns / 1ps
module bn3_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_last_of_frame
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_last_of_frame))
    else $error("stalled result word changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result word right after input word");

endmodule

bind blur_3x3_normalized_border bn3_checker u_bn3_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_red(out_red),
  .out_green(out_green), .out_blue(out_blue), .out_last_of_frame(out_last_of_frame)
);

>>> bench/tb_blur_3x3_normalized_border.sv
// tb_blur_3x3_normalized_border: self-checking bench for the normalized 3x3 RGB blur.
// Drives frames with random stalls and gaps, predicts each output word, checks it.
// Depends on bn3_pkg and blur_3x3_normalized_border.
`timescale 1ns / 1ps
module tb_blur_3x3_normalized_border;

  localparam int LINE_MAX = 1024;
  localparam int SETTLE = 30;
  localparam int STUCK_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blur_word_t;

  class blur_score;
    logic [23:0] older_line[LINE_MAX];
    logic [23:0] newer_line[LINE_MAX];
    logic [23:0] win[3][3];
    int unsigned in_line, in_pos, out_line, out_pos;
    logic [bn3_pkg::LL_BITS-1:0] len_reg;
    logic [bn3_pkg::FL_BITS-1:0] lines_reg;
    logic [bn3_pkg::CFG_DATA_BITS-1:0] wreg[3];
    blur_word_t pending[$];
    int errors;
    int results;

    function void reset_state();
      foreach (win[c, r]) win[c][r] = '0;
      in_line = 0; in_pos = 0; out_line = 0; out_pos = 0;
      len_reg = bn3_pkg::RST_LINE_LENGTH;
      lines_reg = bn3_pkg::RST_FRAME_LINES;
      wreg[0] = bn3_pkg::RST_WEIGHTS_SIDE;
      wreg[1] = bn3_pkg::RST_WEIGHTS_CENTER;
      wreg[2] = bn3_pkg::RST_WEIGHTS_SIDE;
      errors = 0;
      results = 0;
    endfunction

    function void set_reg(logic [bn3_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [bn3_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        bn3_pkg::REG_LINE_LENGTH:    len_reg = data[bn3_pkg::LL_BITS-1:0];
        bn3_pkg::REG_FRAME_LINES:    lines_reg = data[bn3_pkg::FL_BITS-1:0];
        bn3_pkg::REG_WEIGHTS_BEFORE: wreg[0] = data;
        bn3_pkg::REG_WEIGHTS_CENTER: wreg[1] = data;
        bn3_pkg::REG_WEIGHTS_AFTER:  wreg[2] = data;
        default: ;
      endcase
    endfunction

    function int unsigned eff_len();
      if (len_reg < 1) return 1;
      if (len_reg > LINE_MAX) return LINE_MAX;
      return len_reg;
    endfunction

    function int unsigned eff_lines();
      return (lines_reg == 0) ? 1 : lines_reg;
    endfunction

    function bit flushing();
      return in_line >= eff_lines();
    endfunction

    function longint tap_weight(int c, int r);
      logic [15:0] v;
      v = wreg[c][16*r +: 16];
      return longint'($signed(v));
    endfunction

    // returns 0 when the word is ignored (drain inside a frame)
    function bit note_word(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                           logic drain);
      int unsigned len, lines, p;
      bit emit, last;
      logic [23:0] px, o, n;
      longint s, ws, q;
      blur_word_t e;
      len = eff_len();
      lines = eff_lines();
      if (drain && !flushing()) return 0;
      px = flushing() ? 24'd0 : {blue, green, red};
      p = (in_pos >= len) ? len - 1 : in_pos;
      o = older_line[p];
      n = newer_line[p];
      older_line[p] = n;
      newer_line[p] = px;
      for (int c = 0; c < 2; c++)
        for (int r = 0; r < 3; r++) win[c][r] = win[c+1][r];
      win[2][0] = o;
      win[2][1] = n;
      win[2][2] = px;
      emit = in_line >= 2 || (in_line == 1 && p >= 1);
      in_pos = p + 1;
      if (in_pos >= len) begin
        in_pos = 0;
        in_line++;
      end
      if (!emit) return 1;
      for (int ch = 0; ch < 3; ch++) begin
        s = 0;
        ws = 0;
        for (int c = 0; c < 3; c++) begin
          if (c == 0 && out_pos == 0) continue;
          if (c == 2 && out_pos + 1 >= len) continue;
          for (int r = 0; r < 3; r++) begin
            if (r == 0 && out_line == 0) continue;
            if (r == 2 && out_line + 1 >= lines) continue;
            s += longint'(win[c][r][8*ch +: 8]) * tap_weight(c, r);
            ws += tap_weight(c, r);
          end
        end
        if (s == 0 || ws == 0 || ((s > 0) != (ws > 0))) q = 0;
        else begin
          q = (s < 0 ? -s : s) / (ws < 0 ? -ws : ws);
          if (q > 255) q = 255;
        end
        case (ch)
          0: e.red = q[7:0];
          1: e.green = q[7:0];
          default: e.blue = q[7:0];
        endcase
      end
      last = (out_line + 1 >= lines) && (out_pos + 1 >= len);
      e.last = last;
      pending.push_back(e);
      if (last) begin
        in_line = 0; in_pos = 0; out_line = 0; out_pos = 0;
      end else begin
        out_pos++;
        if (out_pos >= len) begin
          out_pos = 0;
          out_line++;
        end
      end
      return 1;
    endfunction

    function void check_word(blur_word_t got);
      blur_word_t exp_w;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word r=%0d g=%0d b=%0d last=%0d", $time,
                 got.red, got.green, got.blue, got.last);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (exp_w.red !== got.red) begin
        $display("%0t: red expected %0d actual %0d", $time, exp_w.red, got.red);
        errors++;
      end
      if (exp_w.green !== got.green) begin
        $display("%0t: green expected %0d actual %0d", $time, exp_w.green, got.green);
        errors++;
      end
      if (exp_w.blue !== got.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, exp_w.blue, got.blue);
        errors++;
      end
      if (exp_w.last !== got.last) begin
        $display("%0t: last_of_frame expected %0d actual %0d", $time, exp_w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic in_drain = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_red, out_green, out_blue;
  logic out_last_of_frame;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bn3_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [bn3_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  blur_3x3_normalized_border dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_drain(in_drain),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_last_of_frame(out_last_of_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  blur_score sb = new();
  bit quiet = 0;
  int words_sent = 0;
  int frames_done = 0;
  int stuck = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word({out_red, out_green, out_blue, out_last_of_frame});
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_word(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic d);
    if (!quiet && in_valid && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_drain <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_word(r, g, b, d)) words_sent++;
  endtask

  task automatic cfg_write(logic [bn3_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [bn3_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [bn3_pkg::LL_BITS-1:0] len,
                           logic [bn3_pkg::FL_BITS-1:0] lines,
                           logic [bn3_pkg::CFG_DATA_BITS-1:0] wb,
                           logic [bn3_pkg::CFG_DATA_BITS-1:0] wc,
                           logic [bn3_pkg::CFG_DATA_BITS-1:0] wa);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write(bn3_pkg::REG_LINE_LENGTH, bn3_pkg::CFG_DATA_BITS'(len));
    cfg_write(bn3_pkg::REG_FRAME_LINES, bn3_pkg::CFG_DATA_BITS'(lines));
    cfg_write(bn3_pkg::REG_WEIGHTS_BEFORE, wb);
    cfg_write(bn3_pkg::REG_WEIGHTS_CENTER, wc);
    cfg_write(bn3_pkg::REG_WEIGHTS_AFTER, wa);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [bn3_pkg::CFG_DATA_BITS-1:0] rand_weights(int mode);
    logic [15:0] w;
    case (mode)
      0: return {16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)),
                 16'($urandom_range(0, 4096))};
      1: return {16'($urandom), 32'($urandom)};
      2: return '0;
      3: begin
        w = 16'($urandom);
        return {16'd0, -w, w};
      end
      default: return '1;
    endcase
  endfunction

  // one frame of pixels, then drains until the final word is predicted
  task automatic run_frame(bit noise);
    int unsigned total;
    total = sb.eff_len() * sb.eff_lines();
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 11) == 0)
        send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      send_word(rand_sample(), rand_sample(), rand_sample(), 1'b0);
    end
    while (sb.flushing()) begin
      if (noise && $urandom_range(0, 7) == 0)
        send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      else
        send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    end
    frames_done++;
  endtask

  task automatic random_phase(bit noise);
    int unsigned len, lines;
    case ($urandom_range(0, 9))
      0: len = $urandom_range(13, 64);
      1: len = $urandom_range(0, 2);
      default: len = $urandom_range(3, 12);
    endcase
    lines = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    configure(bn3_pkg::LL_BITS'(len), bn3_pkg::FL_BITS'(lines),
              rand_weights($urandom_range(0, 4)), rand_weights($urandom_range(0, 4)),
              rand_weights($urandom_range(0, 4)));
    repeat ($urandom_range(1, 3)) run_frame(noise);
  endtask

  initial begin
    sb.reset_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: single-pixel frame at full scale
    send_word(8'd255, 8'd0, 8'd255, 1'b0);
    while (sb.flushing()) send_word(8'd0, 8'd0, 8'd0, 1'b1);
    // zero line length and frame lines, zero weight sum
    configure('0, '0, '0, '0, '0);
    send_word(8'd255, 8'd255, 8'd255, 1'b0);
    while (sb.flushing()) send_word(8'd0, 8'd0, 8'd0, 1'b1);
    // all-negative weights, drain inside the frame, pixel during flush
    configure(11'd3, 16'd2, '1, '1, '1);
    send_word(8'd255, 8'd255, 8'd255, 1'b0);
    send_word(8'd1, 8'd2, 8'd3, 1'b1);
    for (int i = 0; i < 5; i++) send_word(8'(i * 60), 8'd255, 8'd0, 1'b0);
    send_word(8'd77, 8'd88, 8'd99, 1'b0);
    while (sb.flushing()) send_word(8'd0, 8'd0, 8'd0, 1'b1);
    // negative middle tap in the before weights, random center and after weights
    configure(11'd2, 16'd2, {16'd0, 16'hF000, 16'd0}, rand_weights(0), rand_weights(0));
    run_frame(0);

    // long line and a tall frame
    configure(11'd160, 16'd2, rand_weights(0), rand_weights(0), rand_weights(0));
    run_frame(1);
    configure(11'd1, 16'd300, rand_weights(0), rand_weights(0), rand_weights(0));
    run_frame(1);

    while (words_sent < 1450) random_phase(1);
    quiet = 1;
    repeat (3) random_phase(0);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d input words over %0d frames, %0d output words checked",
             words_sent, frames_done, sb.results);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/bn3_pkg.sv
design/bn3_ram.sv
design/bn3_chan.sv
design/blur_3x3_normalized_border.sv
design/bn3_checker.sv
bench/tb_blur_3x3_normalized_border.sv
